@@ rtl/bsc_pkg.sv @@
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types, codes and character helpers for the base64 stream codec.
// ----------------------------------------------------------------------------
package bsc_pkg;

  // operation select codes
  localparam logic FUNC_ENCODE = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  // ascii anchors of the standard alphabet
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_LOWER_A = 8'h61;
  localparam logic [7:0] ASCII_DIGIT_0 = 8'h30;
  localparam logic [7:0] ASCII_PLUS    = 8'h2b;
  localparam logic [7:0] ASCII_SLASH   = 8'h2f;
  localparam logic [7:0] ASCII_PAD     = 8'h3d;

  // results one item can cause, and a count wide enough to hold it
  localparam int unsigned MaxResults = 4;
  localparam int unsigned ResCntW    = $clog2(MaxResults + 1);

  typedef struct packed {
    logic       func;
    logic [7:0] in_byte;
    logic       msg_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       msg_done;
  } out_item_t;

  // six-bit value of a character and whether it is in the alphabet
  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } dec_val_t;

  // six-bit index to alphabet character
  function automatic logic [7:0] enc_char(input logic [5:0] idx);
    logic [7:0] c;
    priority if (idx < 6'd26) begin
      c = ASCII_UPPER_A + {2'b00, idx};
    end else if (idx < 6'd52) begin
      c = ASCII_LOWER_A + {2'b00, idx} - 8'd26;
    end else if (idx < 6'd62) begin
      c = ASCII_DIGIT_0 + {2'b00, idx} - 8'd52;
    end else if (idx == 6'd62) begin
      c = ASCII_PLUS;
    end else begin
      c = ASCII_SLASH;
    end
    return c;
  endfunction

  // alphabet character to six-bit value
  function automatic dec_val_t dec_value(input logic [7:0] c);
    dec_val_t d;
    d.ok  = 1'b1;
    d.val = 6'd0;
    priority if (c >= ASCII_UPPER_A && c <= 8'h5a) begin
      d.val = 6'(c - ASCII_UPPER_A);
    end else if (c >= ASCII_LOWER_A && c <= 8'h7a) begin
      d.val = 6'(c - ASCII_LOWER_A + 8'd26);
    end else if (c >= ASCII_DIGIT_0 && c <= 8'h39) begin
      d.val = 6'(c - ASCII_DIGIT_0 + 8'd52);
    end else if (c == ASCII_PLUS) begin
      d.val = 6'd62;
    end else if (c == ASCII_SLASH) begin
      d.val = 6'd63;
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

  // left-align a partial decode group of cnt characters in 24 bits
  function automatic logic [23:0] dec_align(input logic [23:0] bits, input logic [2:0] cnt);
    logic [23:0] al;
    unique case (cnt)
      3'd4:    al = bits;
      3'd3:    al = {bits[17:0], 6'b0};
      3'd2:    al = {bits[11:0], 12'b0};
      default: al = 24'b0;
    endcase
    return al;
  endfunction

endpackage

@@ rtl/base64_stream_codec.sv @@
// ----------------------------------------------------------------------------
// base64_stream_codec
// Streaming base64 encoder / decoder, standard alphabet, one byte per item.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | in_item_t  (func, in_byte, msg_last)
//  out_    | output    | out_valid/out_stall| out_item_t (out_byte, run_last, msg_done)
//
//  An item is decoded in the cycle it is accepted; its 0 to 4 results go to a
//  pending buffer and leave through the output register at one per cycle,
//  unless out_stall holds them. An item that yields results holds in_stall
//  until its last result can move; the next item is taken as it moves out.
//  Synchronous active-low reset clears group state, buffer count and out_valid.
//  out_stall freezes a valid output register and the pending buffer behind it;
//  in_stall stays high until the last pending result can move.
// ----------------------------------------------------------------------------
module base64_stream_codec
  import bsc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // group state
  logic [23:0] group_bits_r, group_bits_nxt;
  logic [1:0]  group_count_r, group_count_nxt;
  logic        stopped_r, stopped_nxt;

  // pending results of the last accepted item
  logic [7:0]         pend_bytes_r [MaxResults];
  logic [ResCntW-1:0] pend_cnt_r;
  logic               pend_last_r;

  // output register
  logic      out_valid_r;
  out_item_t out_data_r;

  logic               in_accept;
  logic               move;
  logic [7:0]         res_bytes [MaxResults];
  logic [ResCntW-1:0] res_cnt;

  assign move      = (pend_cnt_r != '0) && (!out_valid_r || !out_stall);
  assign in_stall  = (pend_cnt_r != '0) && !((pend_cnt_r == ResCntW'(1)) && move);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // per-item encode / decode
  always_comb begin
    logic [23:0] sh;
    logic [23:0] al;
    logic [23:0] src;
    logic [2:0]  fc;
    logic        do_flush;
    dec_val_t    dv;

    sh       = {group_bits_r[15:0], in_data.in_byte};
    al       = 24'b0;
    src      = group_bits_r;
    fc       = 3'd0;
    do_flush = 1'b0;
    dv       = dec_value(in_data.in_byte);

    group_bits_nxt  = group_bits_r;
    group_count_nxt = group_count_r;
    stopped_nxt     = stopped_r;
    res_cnt         = '0;
    for (int k = 0; k < MaxResults; k++) begin
      res_bytes[k] = ASCII_PAD;
    end

    if (in_accept) begin
      if (in_data.func == FUNC_ENCODE) begin
        // full group of three bytes
        if (group_count_r[1]) begin
          res_bytes[0]    = enc_char(sh[23:18]);
          res_bytes[1]    = enc_char(sh[17:12]);
          res_bytes[2]    = enc_char(sh[11:6]);
          res_bytes[3]    = enc_char(sh[5:0]);
          res_cnt         = ResCntW'(MaxResults);
          group_bits_nxt  = 24'b0;
          group_count_nxt = 2'd0;
        end else begin
          group_bits_nxt  = sh;
          group_count_nxt = group_count_r + 2'd1;
          // partial group flush with padding
          if (in_data.msg_last) begin
            al = group_count_r[0] ? {sh[15:0], 8'b0} : {sh[7:0], 16'b0};
            res_bytes[0] = enc_char(al[23:18]);
            res_bytes[1] = enc_char(al[17:12]);
            res_bytes[2] = group_count_r[0] ? enc_char(al[11:6]) : ASCII_PAD;
            res_cnt      = ResCntW'(MaxResults);
          end
        end
      end else if (!stopped_r) begin
        if (!dv.ok) begin
          // stop character: flush what is held
          src             = group_bits_r;
          fc              = {1'b0, group_count_r};
          do_flush        = 1'b1;
          stopped_nxt     = 1'b1;
          group_bits_nxt  = 24'b0;
          group_count_nxt = 2'd0;
        end else begin
          src             = {group_bits_r[17:0], dv.val};
          fc              = {1'b0, group_count_r} + 3'd1;
          group_bits_nxt  = src;
          group_count_nxt = fc[1:0];
          if (fc == 3'd4 || in_data.msg_last) begin
            do_flush        = 1'b1;
            group_bits_nxt  = 24'b0;
            group_count_nxt = 2'd0;
          end
        end
        if (do_flush) begin
          al           = dec_align(src, fc);
          res_bytes[0] = al[23:16];
          res_bytes[1] = al[15:8];
          res_bytes[2] = al[7:0];
          res_cnt      = (fc >= 3'd2) ? ResCntW'(fc - 3'd1) : '0;
        end
      end
      // message end clears everything
      if (in_data.msg_last) begin
        group_bits_nxt  = 24'b0;
        group_count_nxt = 2'd0;
        stopped_nxt     = 1'b0;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_bits_r  <= 24'b0;
      group_count_r <= 2'd0;
      stopped_r     <= 1'b0;
      pend_cnt_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      group_bits_r  <= group_bits_nxt;
      group_count_r <= group_count_nxt;
      stopped_r     <= stopped_nxt;
      if (in_accept) begin
        pend_cnt_r <= res_cnt;
      end else if (move) begin
        pend_cnt_r <= pend_cnt_r - ResCntW'(1);
      end
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers: pending buffer shifts toward slot 0
  always_ff @(posedge clk) begin
    if (in_accept) begin
      pend_bytes_r <= res_bytes;
      pend_last_r  <= in_data.msg_last;
    end else if (move) begin
      for (int k = 0; k < MaxResults - 1; k++) begin
        pend_bytes_r[k] <= pend_bytes_r[k+1];
      end
    end
    if (move) begin
      out_data_r.out_byte <= pend_bytes_r[0];
      out_data_r.run_last <= (pend_cnt_r == ResCntW'(1));
      out_data_r.msg_done <= (pend_cnt_r == ResCntW'(1)) && pend_last_r;
    end
  end

  // end of message leaves no group state behind
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_data.msg_last |=> group_count_r == 2'd0 && !stopped_r)
    else $error("group state not cleared after message end");

  // a result that is not the item's last has more waiting behind it
  a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.run_last |-> pend_cnt_r != '0)
    else $error("non-final result with empty pending buffer");

  // message end only on the item's last result
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.msg_done |-> out_data_r.run_last)
    else $error("msg_done without run_last");

  // pending buffer never overfills
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_cnt_r <= ResCntW'(MaxResults))
    else $error("pending count out of range");

endmodule

@@ dv/base64_stream_codec_test.sv @@
// ----------------------------------------------------------------------------
// base64_stream_codec_test
// Self-checking bench for the streaming base64 codec. A short table of
// directed transactions (known vectors, pad and stop characters, mixed
// modes) is followed by random messages: plain encode, well-formed decode,
// decode broken by a stop character, and mixed noise. Every accepted input
// runs through a local codec predictor and every result is compared field by
// field against the oldest expected entry. Both channels idle and stall at
// random, with calm stretches in between.
// ----------------------------------------------------------------------------
module base64_stream_codec_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bsc_pkg::*;

  localparam int DirRows    = 24;
  localparam int RandItems  = 86;
  localparam int DrainCycles = 32;
  localparam int CycleLimit = 200000;
  localparam int MaxPrinted = 50;

  // standard alphabet, index 0 in the top byte
  localparam logic [8*64-1:0] B64Chars =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // one stimulus row: the item, plus typed expectations when fixed is set
  typedef struct packed {
    in_item_t             item;
    logic                 fixed;
    logic [2:0]           n;
    out_item_t [0:3]      res;
  } stim_row_t;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // predictor state
  logic [23:0] grp_bits   = '0;
  logic [1:0]  grp_cnt    = '0;
  logic        dec_halted = 1'b0;
  out_item_t   pred_res [0:3];
  int          pred_n;

  stim_row_t   dir_table [DirRows];
  stim_row_t   row_q [$];
  out_item_t   byte_q [$];
  stim_row_t   acc_row;
  out_item_t   chk_want;
  int          mon_k;
  int          err_count   = 0;
  int          items_sent  = 0;
  int          cycle_count = 0;
  logic        calm        = 1'b0;

  base64_stream_codec DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // alphabet lookups
  function automatic logic [7:0] alpha_char(logic [5:0] idx);
    return B64Chars[8*(63 - idx) +: 8];
  endfunction

  function automatic int char_index(logic [7:0] c);
    int i;
    for (i = 0; i < 64; i++) begin
      if (alpha_char(6'(i)) == c) return i;
    end
    return -1;
  endfunction

  // append one predicted result
  function automatic void push_pred(logic [7:0] b);
    pred_res[pred_n] = {b, 1'b0, 1'b0};
    pred_n++;
  endfunction

  // emit cnt - 1 bytes of a partial decode group
  function automatic void flush_decode(int cnt);
    logic [23:0] al;
    int k;
    if (cnt >= 2) begin
      al = grp_bits << (6 * (4 - cnt));
      for (k = 0; k + 1 < cnt && k < 3; k++) push_pred(al[16 - 8*k +: 8]);
    end
  endfunction

  // codec predictor: results of one accepted transaction
  function automatic void codec_predict(in_item_t it);
    logic [23:0] al;
    int cnt;
    int v;
    int k;
    pred_n = 0;
    if (it.func == FUNC_ENCODE) begin
      cnt = grp_cnt + 1;
      grp_bits = {grp_bits[15:0], it.in_byte};
      if (cnt >= 3) begin
        for (k = 0; k < 4; k++) push_pred(alpha_char(grp_bits[18 - 6*k +: 6]));
        grp_bits = '0;
        cnt = 0;
      end else if (it.msg_last) begin
        // partial group: cnt + 1 characters, then pad
        al = grp_bits << (8 * (3 - cnt));
        for (k = 0; k < 4; k++) begin
          push_pred((k <= cnt) ? alpha_char(al[18 - 6*k +: 6]) : ASCII_PAD);
        end
        cnt = 0;
      end
      grp_cnt = 2'(cnt);
    end else if (!dec_halted) begin
      v = char_index(it.in_byte);
      if (v < 0) begin
        // stop character: flush and ignore the rest of the message
        flush_decode(grp_cnt);
        grp_bits = '0;
        grp_cnt = '0;
        dec_halted = 1'b1;
      end else begin
        cnt = grp_cnt + 1;
        grp_bits = {grp_bits[17:0], 6'(v)};
        if (cnt >= 4 || it.msg_last) begin
          flush_decode(cnt);
          grp_bits = '0;
          cnt = 0;
        end
        grp_cnt = 2'(cnt);
      end
    end
    if (pred_n > 0) begin
      pred_res[pred_n-1].run_last = 1'b1;
      if (it.msg_last) pred_res[pred_n-1].msg_done = 1'b1;
    end
    if (it.msg_last) begin
      grp_bits = '0;
      grp_cnt = '0;
      dec_halted = 1'b0;
    end
  endfunction

  // stimulus rows
  function automatic stim_row_t plain_row(logic f, logic [7:0] b, logic l);
    stim_row_t r;
    r = '0;
    r.item = {f, b, l};
    return r;
  endfunction

  // row with typed results, first character in the top byte of chars
  function automatic stim_row_t fixed_row(logic f, logic [7:0] b, logic l, int n,
                                          logic [31:0] chars);
    stim_row_t r;
    int k;
    r = plain_row(f, b, l);
    r.fixed = 1'b1;
    r.n = 3'(n);
    for (k = 0; k < n; k++) begin
      r.res[k] = {chars[31 - 8*k -: 8], (k == n - 1), (k == n - 1) && l};
    end
    return r;
  endfunction

  function automatic int pick_wait();
    if (calm || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 12);
  endfunction

  task automatic report(string what, logic [7:0] got, logic [7:0] want);
    err_count++;
    if (err_count <= MaxPrinted) begin
      $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
    end
  endtask

  // drive one transaction and wait for it to be taken
  task automatic send_item(stim_row_t r);
    int gap;
    gap = pick_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    row_q = {row_q, r};
    in_data  <= r.item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // one random message
  task automatic send_random_message();
    int len;
    int kind;
    int stop_at;
    int k;
    logic f;
    logic [7:0] b;
    len = $urandom_range(1, 9);
    kind = $urandom_range(0, 9);
    calm = ($urandom_range(0, 3) == 0);
    stop_at = (kind >= 7 && kind <= 8) ? $urandom_range(0, len - 1) : len;
    for (k = 0; k < len; k++) begin
      if (kind < 4) begin
        f = FUNC_ENCODE;
        b = 8'($urandom);
      end else if (kind < 9) begin
        f = FUNC_DECODE;
        if (k == stop_at) b = $urandom_range(0, 1) ? ASCII_PAD : 8'($urandom);
        else if (k > stop_at) b = 8'($urandom);
        else b = alpha_char(6'($urandom_range(0, 63)));
      end else begin
        f = 1'($urandom);
        b = 8'($urandom);
      end
      send_item(plain_row(f, b, k == len - 1));
    end
  endtask

  // input monitor: predict every accepted transaction
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      codec_predict(in_data);
      acc_row = row_q.pop_front();
      if (acc_row.fixed) begin
        for (mon_k = 0; mon_k < acc_row.n; mon_k++) byte_q = {byte_q, acc_row.res[mon_k]};
      end else begin
        for (mon_k = 0; mon_k < pred_n; mon_k++) byte_q = {byte_q, pred_res[mon_k]};
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (byte_q.size() == 0) begin
        report("result with nothing expected", out_data.out_byte, 8'h00);
      end else begin
        chk_want = byte_q.pop_front();
        if (out_data.out_byte !== chk_want.out_byte)
          report("out_byte", out_data.out_byte, chk_want.out_byte);
        if (out_data.run_last !== chk_want.run_last)
          report("run_last", 8'(out_data.run_last), 8'(chk_want.run_last));
        if (out_data.msg_done !== chk_want.msg_done)
          report("msg_done", 8'(out_data.msg_done), 8'(chk_want.msg_done));
      end
    end
  end

  // result side: random stall before each transaction
  initial begin
    int k;
    wait (rst_n);
    forever begin
      k = pick_wait();
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  // main sequence
  initial begin
    int i;
    dir_table = '{
      // encode "Man"
      fixed_row(FUNC_ENCODE, "M", 1'b0, 0, 32'h0),
      fixed_row(FUNC_ENCODE, "a", 1'b0, 0, 32'h0),
      fixed_row(FUNC_ENCODE, "n", 1'b1, 4, "TWFu"),
      // decode "TWFu"
      fixed_row(FUNC_DECODE, "T", 1'b0, 0, 32'h0),
      fixed_row(FUNC_DECODE, "W", 1'b0, 0, 32'h0),
      fixed_row(FUNC_DECODE, "F", 1'b0, 0, 32'h0),
      fixed_row(FUNC_DECODE, "u", 1'b1, 3, {"Man", 8'h00}),
      // single byte extremes, padded
      fixed_row(FUNC_ENCODE, 8'h00, 1'b1, 4, "AA=="),
      fixed_row(FUNC_ENCODE, 8'hff, 1'b1, 4, "/w=="),
      // lone stop character as last item: nothing at all
      fixed_row(FUNC_DECODE, 8'hff, 1'b1, 0, 32'h0),
      // two byte encode with one pad
      plain_row(FUNC_ENCODE, 8'h00, 1'b0),
      plain_row(FUNC_ENCODE, 8'hff, 1'b1),
      // pad stops decode, later items ignored, last one yields nothing
      plain_row(FUNC_DECODE, "Q", 1'b0),
      plain_row(FUNC_DECODE, "U", 1'b0),
      plain_row(FUNC_DECODE, "=", 1'b0),
      plain_row(FUNC_DECODE, "x", 1'b0),
      plain_row(FUNC_DECODE, "A", 1'b1),
      // single leftover character
      plain_row(FUNC_DECODE, "Z", 1'b1),
      // stop character that is last flushes with msg_done
      plain_row(FUNC_DECODE, "+", 1'b0),
      plain_row(FUNC_DECODE, "/", 1'b0),
      plain_row(FUNC_DECODE, "*", 1'b1),
      // modes mixed inside one message
      plain_row(FUNC_ENCODE, 8'h12, 1'b0),
      plain_row(FUNC_DECODE, "A", 1'b0),
      plain_row(FUNC_ENCODE, 8'h34, 1'b1)
    };

    // reset
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (i = 0; i < DirRows; i++) send_item(dir_table[i]);

    // random messages
    while (items_sent < DirRows + RandItems) send_random_message();
    in_valid <= 1'b0;

    // drain
    while (byte_q.size() != 0 || row_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (byte_q.size() != 0) report("results still expected", 8'(byte_q.size()), 8'h00);

    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
